### sv/tss_pkg.sv
`default_nettype none

package tss_pkg;

  localparam int unsigned MAX_TERM_LEN = 8;

  localparam logic [63:0] TERM_BYTES_RESET  = 64'h0000_000A_0D2E_0A0D;
  localparam logic [3:0]  TERM_LENGTH_RESET = 4'd5;

  localparam logic REG_TERM_BYTES  = 1'b0;
  localparam logic REG_TERM_LENGTH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic eval;         // input word accepted: update match state
    logic emit_direct;  // load the result of the accepted word straight into the output
    logic emit_flush;   // load the next held terminator byte
    logic emit_held;    // load the stored result of the last word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;       // output register can take a word this cycle
    logic flush;          // accepted word breaks a partial match
    logic emit_now;       // accepted word gives a result and nothing is held
    logic flush_last;     // current flush byte is the last held one
    logic final_pending;  // a result still follows the flush
  } sts_t;

endpackage

`default_nettype wire

### sv/tss_datapath.sv
`default_nettype none

module tss_datapath
  import tss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic [7:0]  s_tdata,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  logic [63:0] term_bytes;
  logic [3:0]  term_length;
  logic [2:0]  pos;
  logic [2:0]  cnt;
  logic [2:0]  idx;
  logic [7:0]  held_byte;
  logic        held_found;
  logic        final_pending;

  logic [3:0]  eff_len;
  logic [2:0]  pos0;
  logic        flush;
  logic        hit;
  logic        done;
  logic        emit_final;
  logic [2:0]  pos_next;
  logic [7:0]  res_byte;
  logic        out_free;
  logic        flush_last;

  always_comb begin
    if (term_length == 4'd0) begin
      eff_len = 4'd1;
    end else if (term_length > 4'(MAX_TERM_LEN)) begin
      eff_len = 4'(MAX_TERM_LEN);
    end else begin
      eff_len = term_length;
    end
  end

  assign flush      = (pos != 3'd0) && (s_tdata != term_bytes[pos*8 +: 8]);
  assign pos0       = flush ? 3'd0 : pos;
  assign hit        = (s_tdata == term_bytes[pos0*8 +: 8]);
  assign done       = hit && (({1'b0, pos0} + 4'd1) >= eff_len);
  assign emit_final = !hit || done;
  assign pos_next   = hit ? (done ? 3'd0 : pos0 + 3'd1) : 3'd0;
  assign res_byte   = done ? 8'd0 : s_tdata;
  assign out_free   = !m_tvalid || m_tready;
  assign flush_last = (idx == cnt - 3'd1);

  always_comb begin
    sts.out_free      = out_free;
    sts.flush         = flush;
    sts.emit_now      = !flush && emit_final;
    sts.flush_last    = flush_last;
    sts.final_pending = final_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_bytes    <= TERM_BYTES_RESET;
      term_length   <= TERM_LENGTH_RESET;
      pos           <= 3'd0;
      final_pending <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TERM_BYTES:  term_bytes  <= cfg_data;
          REG_TERM_LENGTH: term_length <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        pos           <= pos_next;
        final_pending <= emit_final;
      end
      if (cmd.emit_direct || cmd.emit_flush || cmd.emit_held) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cnt        <= pos;
      idx        <= 3'd0;
      held_byte  <= res_byte;
      held_found <= done;
    end
    if (cmd.emit_direct) begin
      m_tdata <= res_byte;
      m_tuser <= done;
      m_tlast <= 1'b1;
    end else if (cmd.emit_flush) begin
      m_tdata <= term_bytes[idx*8 +: 8];
      m_tuser <= 1'b0;
      m_tlast <= flush_last && !final_pending;
      idx     <= idx + 3'd1;
    end else if (cmd.emit_held) begin
      m_tdata <= held_byte;
      m_tuser <= held_found;
      m_tlast <= 1'b1;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_direct || cmd.emit_flush || cmd.emit_held) |-> out_free)
    else $error("output loaded while stalled");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_flush |-> cnt != 3'd0)
    else $error("flush with nothing held");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'd0 && m_tlast))
    else $error("found marker carries data");

endmodule

`default_nettype wire

### sv/tss_controller.sv
`default_nettype none

module tss_controller
  import tss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {
    IDLE,
    FLUSH,
    FINAL
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE) && sts.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.eval = 1'b1;
          if (sts.flush) begin
            state_next = FLUSH;
          end else if (sts.emit_now) begin
            cmd.emit_direct = 1'b1;
          end
        end
      end
      FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.flush_last) begin
            state_next = sts.final_pending ? FINAL : IDLE;
          end
        end
      end
      FINAL: begin
        if (sts.out_free) begin
          cmd.emit_held = 1'b1;
          state_next    = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_direct, cmd.emit_flush, cmd.emit_held}))
    else $error("more than one output load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_flush || cmd.emit_held) |-> !cmd.eval)
    else $error("input taken during flush");

endmodule

`default_nettype wire

### sv/terminator_sequence_stripper_core.sv
`default_nettype none

// Byte stream filter that removes a terminator sequence of 1 to 8 bytes
// (term_bytes, first byte lowest; term_length, 0 acts as 1) and sends a
// found marker (tuser high, tdata zero) in its place. Bytes that extend a
// partial match are held back and give no output word; when a later byte breaks
// the match, the held bytes are replayed from term_bytes and the breaking byte
// is checked again from the first terminator byte (no overlap search). tlast
// marks the last output word caused by an input word. A byte that passes or
// completes the terminator goes straight to the single output register; a
// byte that breaks a match of p bytes sends the p replayed words, then its own
// result if any, and no new byte is taken meanwhile. Configuration writes
// belong in idle periods only. Reset terminator is CR LF '.' CR LF.
module terminator_sequence_stripper_core
  import tss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tuser,   // found
  output logic             m_tlast
);

  cmd_t cmd;
  sts_t sts;

  tss_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tss_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
